// ===== sv/moesi_pkg.sv =====
// Shared types for the MOESI line state machine: state, transaction and
// action codes, and the result bundle. No dependencies.
`default_nettype none

package moesi_pkg;

  // Line coherence state
  typedef enum logic [2:0] {
    ST_M = 3'd0,
    ST_O = 3'd1,
    ST_E = 3'd2,
    ST_S = 3'd3,
    ST_I = 3'd4
  } state_e;

  // Transaction kind; codes above F_FORCE are unused
  typedef enum logic [3:0] {
    F_DR     = 4'd0,
    F_TR     = 4'd1,
    F_DW     = 4'd2,
    F_TW     = 4'd3,
    F_DWB    = 4'd4,
    F_TWB    = 4'd5,
    F_DIR_DR = 4'd6,
    F_DIR_TR = 4'd7,
    F_DIR_DW = 4'd8,
    F_DIR_TW = 4'd9,
    F_FORCE  = 4'd10
  } func_e;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_MEM_DWB = 3'd1,
    ACT_MEM_TWB = 3'd2,
    ACT_BC_DW   = 3'd3,
    ACT_BC_TW   = 3'd4,
    ACT_BC_DR   = 3'd5,
    ACT_BC_TR   = 3'd6
  } action_e;

  localparam int unsigned LEVEL_W = 2;
  localparam logic [LEVEL_W-1:0] LEVEL_FIRST = 2'd1;

  typedef struct packed {
    action_e action;
    state_e  state;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/moesi_line_state_machine.sv =====
// Top level of the MOESI coherence state machine for one cache line.
// Depends on moesi_pkg and moesi_next_state.
`default_nettype none

// Channel   Direction  Handshake                  Payload
// in        sink       in_valid_i / in_stall_o    func_i, propagate_state_i
// out       source     out_valid_o / out_stall_i  action_o, new_state_o
// cfg       sink       cfg_we_i                   cfg_data_i (hierarchy level)
//
// Two register stages: an input register, then the transition table, then the
// result register. The line state updates as an item moves into the result
// register, so items follow back to back at one per cycle while not stalled.
// Reset leaves the line Invalid and the hierarchy level at 1.
// A stall on the output holds the result; an empty input register still fills,
// so one more item is taken before in_stall_o rises.

module moesi_line_state_machine (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [moesi_pkg::LEVEL_W-1:0]   cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [3:0]                      func_i,
  input  logic [2:0]                      propagate_state_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [2:0]                      action_o,
  output logic [2:0]                      new_state_o
);
  import moesi_pkg::*;

  logic [LEVEL_W-1:0] level_q;

  // input stage
  logic       s1_valid_q;
  logic [3:0] func_q;
  logic [2:0] prop_q;

  // result stage
  logic       out_valid_q;
  result_t    res_q;
  result_t    res_d;

  state_e     line_state_q;

  logic       s2_ready;
  logic       s1_ready;
  logic       s1_move;

  assign s2_ready   = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && s2_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_stall_o = !s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= LEVEL_FIRST;
    end else if (cfg_we_i) begin
      level_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      func_q <= func_i;
      prop_q <= propagate_state_i;
    end
  end

  moesi_next_state u_next (
    .func_i  (func_e'(func_q)),
    .prop_i  (prop_q),
    .cur_i   (line_state_q),
    .first_i (level_q == LEVEL_FIRST),
    .res_o   (res_d)
  );

  // state advances exactly once per item, as it enters the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_state_q <= ST_I;
    end else if (s1_move) begin
      line_state_q <= res_d.state;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign action_o    = 3'(res_q.action);
  assign new_state_o = 3'(res_q.state);

endmodule

`default_nettype wire

// ===== sv/moesi_next_state.sv =====
// Combinational MOESI transition table for one transaction.
// Depends on moesi_pkg.
`default_nettype none

module moesi_next_state (
  input  moesi_pkg::func_e   func_i,
  input  logic [2:0]         prop_i,
  input  moesi_pkg::state_e  cur_i,
  input  logic               first_i,
  output moesi_pkg::result_t res_o
);
  import moesi_pkg::*;

  state_e  prop_clean;
  state_e  nxt;
  action_e act;
  action_e wb_act;
  action_e bc_wr_act;
  action_e bc_rd_act;
  logic    dir_rd;
  logic    dir_wr;
  logic    loc_wr;
  logic    loc_wb;
  logic    loc_rd;

  always_comb begin
    // out-of-range propagated states read as Invalid
    prop_clean = (prop_i > 3'(ST_I)) ? ST_I : state_e'(prop_i);

    dir_rd = func_i inside {F_DIR_DR, F_DIR_TR};
    dir_wr = func_i inside {F_DIR_DW, F_DIR_TW};
    loc_wr = func_i inside {F_DW, F_TW};
    loc_wb = func_i inside {F_DWB, F_TWB};
    loc_rd = func_i inside {F_DR, F_TR};

    wb_act    = (func_i == F_DIR_DR || func_i == F_DIR_DW) ? ACT_MEM_DWB : ACT_MEM_TWB;
    bc_wr_act = (func_i == F_DW) ? ACT_BC_DW : ACT_BC_TW;
    bc_rd_act = (func_i == F_DR) ? ACT_BC_DR : ACT_BC_TR;

    nxt = cur_i;
    act = ACT_NONE;

    if (func_i == F_FORCE) begin
      nxt = prop_clean;
    end else begin
      case (cur_i)
        ST_M: begin
          // modified ignores local traffic, writebacks included
          if (dir_rd) begin
            nxt = ST_O;
            act = wb_act;
          end else if (dir_wr) begin
            nxt = ST_I;
            act = wb_act;
          end
        end
        ST_E: begin
          if (dir_rd) begin
            nxt = ST_S;
          end else if (dir_wr) begin
            nxt = ST_I;
          end else if (loc_wr) begin
            nxt = first_i ? ST_M : ST_E;
          end else if (loc_wb) begin
            nxt = prop_clean;
          end
        end
        default: begin
          // owner, shared, invalid
          if (dir_wr) begin
            if (cur_i != ST_I) begin
              nxt = ST_I;
              if (cur_i == ST_O) begin
                act = wb_act;
              end
            end
          end else if (loc_wr) begin
            if (first_i) begin
              nxt = ST_M;
              act = bc_wr_act;
            end else begin
              nxt = ST_E;
            end
          end else if (loc_wb) begin
            nxt = prop_clean;
          end else if (cur_i == ST_I && loc_rd) begin
            nxt = ST_E;
            act = bc_rd_act;
          end
        end
      endcase
    end

    res_o.action = act;
    res_o.state  = nxt;
  end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for moesi_line_state_machine: directed and random
// transactions at several cache levels, checked by an in-file MOESI predictor.
// Depends on moesi_pkg and the RTL of moesi_line_state_machine.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import moesi_pkg::*;

  // Func codes above F_FORCE do nothing; propagated states above ST_I read as I
  localparam logic [3:0] F_UNUSED_LO = 4'd11;
  localparam logic [3:0] F_UNUSED_HI = 4'd15;
  localparam logic [2:0] PROP_BAD_LO = 3'd5;
  localparam logic [2:0] PROP_BAD_HI = 3'd7;

  localparam logic [LEVEL_W-1:0] LEVEL_ZERO = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_TWO  = 2'd2;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 2'd3;

  localparam int unsigned ITEMS_PER_PHASE = 450;
  // two register stages; a few spare cycles before a config write or the end
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned RUN_LIMIT_NS = 2_000_000;

  typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_LONG} stall_mode_e;

  // Predicts the coherence result of each accepted item and matches the
  // results coming out of the block against them in order.
  class coherence_scoreboard;
    state_e              line_st;
    logic [LEVEL_W-1:0]  level;
    result_t             pending_q[$];
    int unsigned         errors;

    function new();
      line_st = ST_I;
      level   = LEVEL_FIRST;
      errors  = 0;
    endfunction

    function result_t next_result(logic [3:0] fn, logic [2:0] ps);
      state_e  prop;
      state_e  nxt;
      action_e act;
      action_e mem_wb;
      bit      first;
      bit      dir_rd;
      bit      dir_wr;
      bit      loc_rd;
      bit      loc_wr;
      bit      loc_wb;
      result_t r;
      prop   = (ps > ST_I) ? ST_I : state_e'(ps);
      nxt    = line_st;
      act    = ACT_NONE;
      first  = (level == LEVEL_FIRST);
      dir_rd = (fn == F_DIR_DR) || (fn == F_DIR_TR);
      dir_wr = (fn == F_DIR_DW) || (fn == F_DIR_TW);
      loc_rd = (fn == F_DR) || (fn == F_TR);
      loc_wr = (fn == F_DW) || (fn == F_TW);
      loc_wb = (fn == F_DWB) || (fn == F_TWB);
      mem_wb = ((fn == F_DIR_DR) || (fn == F_DIR_DW)) ? ACT_MEM_DWB : ACT_MEM_TWB;

      if (fn == F_FORCE) begin
        nxt = prop;
      end else begin
        case (line_st)
          ST_M: begin
            // M gives up data on any directory hit; local traffic is absorbed
            if (dir_rd) begin
              nxt = ST_O;
              act = mem_wb;
            end else if (dir_wr) begin
              nxt = ST_I;
              act = mem_wb;
            end
          end
          ST_E: begin
            if (dir_rd) nxt = ST_S;
            else if (dir_wr) nxt = ST_I;
            else if (loc_wr) nxt = first ? ST_M : ST_E;
            else if (loc_wb) nxt = prop;
          end
          default: begin
            // O, S and I share most of their rules
            if (dir_wr) begin
              if (line_st != ST_I) begin
                nxt = ST_I;
                if (line_st == ST_O) act = mem_wb;
              end
            end else if (loc_wr) begin
              if (first) begin
                nxt = ST_M;
                act = (fn == F_DW) ? ACT_BC_DW : ACT_BC_TW;
              end else begin
                nxt = ST_E;
              end
            end else if (loc_wb) begin
              nxt = prop;
            end else if (line_st == ST_I && loc_rd) begin
              nxt = ST_E;
              act = (fn == F_DR) ? ACT_BC_DR : ACT_BC_TR;
            end
          end
        endcase
      end
      line_st  = nxt;
      r.action = act;
      r.state  = nxt;
      return r;
    endfunction

    function void note_item(logic [3:0] fn, logic [2:0] ps);
      pending_q.push_back(next_result(fn, ps));
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("%0t: mismatch: %s", $realtime, msg);
    endtask

    task check_result(logic [2:0] act, logic [2:0] st);
      result_t exp_r;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("result act=%0d state=%0d with nothing pending", act, st));
      end else begin
        exp_r = pending_q.pop_front();
        if (act !== exp_r.action)
          report_mismatch($sformatf("action %0d, want %0d", act, exp_r.action));
        if (st !== exp_r.state)
          report_mismatch($sformatf("new_state %0d, want %0d", st, exp_r.state));
      end
    endtask
  endclass

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [LEVEL_W-1:0]  cfg_data  = '0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [3:0]          func      = '0;
  logic [2:0]          prop      = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [2:0]          action;
  logic [2:0]          new_state;

  coherence_scoreboard sb = new();

  always #5 clk = ~clk;

  moesi_line_state_machine DUT (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .func_i            (func),
    .propagate_state_i (prop),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .action_o          (action),
    .new_state_o       (new_state)
  );

  // Present one item and hold it until the block takes it. Called at a
  // rising edge; returns at the edge that accepted the item. Valid is left
  // high so back-to-back items need only one assignment per edge.
  task automatic send_item(logic [3:0] fn, logic [2:0] ps);
    in_valid <= 1'b1;
    func     <= fn;
    prop     <= ps;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(fn, ps);
  endtask

  task automatic idle_gap(int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold off until every predicted result is back, then let the pipe settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_level(logic [LEVEL_W-1:0] lvl);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_data <= lvl;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.level = lvl;
  endtask

  // Mostly real transactions; a share of unused codes and bad states
  function automatic logic [3:0] pick_func();
    if ($urandom_range(0, 9) == 0) return 4'($urandom_range(F_UNUSED_LO, F_UNUSED_HI));
    return 4'($urandom_range(F_DR, F_FORCE));
  endfunction

  function automatic logic [2:0] pick_prop();
    if ($urandom_range(0, 4) == 0) return 3'($urandom_range(PROP_BAD_LO, PROP_BAD_HI));
    return 3'($urandom_range(ST_M, ST_I));
  endfunction

  // Bursts of random length with random gaps; some bursts run straight into
  // the next. Halfway through, the sender waits for the block to drain.
  task automatic run_random(int unsigned n);
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 40);
      while (burst != 0 && sent < n) begin
        send_item(pick_func(), pick_prop());
        sent++;
        burst--;
        if (sent == n / 2) wait_drained();
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 6));
    end
  endtask

  // Receiver: check every accepted result, and stall on a pattern that
  // switches between no stall, random, periodic and long stalls.
  stall_mode_e stall_mode = STALL_NONE;
  int unsigned mode_left  = 0;
  int unsigned stall_left = 0;
  int unsigned cyc        = 0;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(action, new_state);
    cyc++;
    if (mode_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      mode_left  = $urandom_range(32, 256);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_RANDOM:   out_stall <= ($urandom_range(0, 2) == 0);
      STALL_PERIODIC: out_stall <= ((cyc % 7) < 3);
      default: begin
        if (stall_left != 0) begin
          stall_left--;
          out_stall <= 1'b1;
        end else if ($urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(1, 8);
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    endcase
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed walk at level 1 (reset value): every transaction kind
    send_item(F_DR, ST_M);              // I -> E, broadcast data read
    send_item(F_DW, ST_O);              // E -> M at level 1
    send_item(F_DIR_DR, ST_E);          // M -> O, data writeback
    send_item(F_TW, ST_S);              // O -> M, broadcast transl write
    send_item(F_DIR_TW, ST_I);          // M -> I, transl writeback
    send_item(F_TR, ST_M);              // I -> E, broadcast transl read
    send_item(F_DIR_TR, ST_M);          // E -> S
    send_item(F_DWB, PROP_BAD_HI);      // bad propagated state reads as I
    send_item(F_FORCE, ST_O);           // force installs O
    send_item(F_DIR_DW, ST_M);          // O -> I, data writeback
    send_item(F_UNUSED_HI, PROP_BAD_HI);// unused code: no change
    send_item(F_FORCE, ST_M);
    send_item(F_TWB, ST_S);             // writeback in M is ignored
    send_item(F_UNUSED_LO, PROP_BAD_LO);
    send_item(F_DIR_TR, ST_I);          // M -> O, transl writeback
    send_item(F_TWB, ST_E);             // O adopts E
    send_item(F_DIR_DW, ST_M);          // E -> I
    send_item(F_DW, ST_I);              // I -> M, broadcast data write

    // Level 0 behaves as a lower level: local writes go to E quietly
    write_level(LEVEL_ZERO);
    send_item(F_FORCE, ST_S);
    send_item(F_TW, ST_M);              // S -> E
    send_item(F_FORCE, ST_I);
    send_item(F_DW, ST_O);              // I -> E
    send_item(F_DWB, 3'd6);             // E adopts bad state -> I
    send_item(4'd12, ST_M);
    send_item(F_TW, ST_M);              // I -> E again, then E stays E
    send_item(F_DW, ST_M);

    // Random phases across all levels, extremes included
    write_level(LEVEL_MAX);
    run_random(ITEMS_PER_PHASE);
    write_level(LEVEL_ZERO);
    run_random(ITEMS_PER_PHASE);
    write_level(LEVEL_FIRST);
    run_random(ITEMS_PER_PHASE);
    write_level(LEVEL_TWO);
    run_random(ITEMS_PER_PHASE);

    wait_drained();
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #(RUN_LIMIT_NS);
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
